// File: design/mssd_pkg.sv
`default_nettype none

package mssd_pkg;

   // Field widths
   localparam int PixelBits = 8;
   localparam int CoordBits = 12;
   localparam int ErrBits   = 26;
   // Sum of three 8-bit squared differences: at most 3 * 255 * 255
   localparam int IncBits   = 18;

   localparam logic [ErrBits-1:0] ErrAllOnes = {ErrBits{1'b1}};

   // One pixel pair as it arrives on the request channel
   typedef struct packed {
      logic [PixelBits-1:0] tgt_red;
      logic [PixelBits-1:0] tgt_green;
      logic [PixelBits-1:0] tgt_blue;
      logic                 tgt_hole;
      logic [PixelBits-1:0] cand_red;
      logic [PixelBits-1:0] cand_green;
      logic [PixelBits-1:0] cand_blue;
      logic                 cand_hole;
      logic [CoordBits-1:0] win_x;
      logic [CoordBits-1:0] win_y;
      logic                 last_in_window;
      logic                 last_window;
   } pixel_pair_type;

   // A pixel pair reduced to its masked error contribution
   typedef struct packed {
      logic [IncBits-1:0]   err_inc;
      logic                 cand_hole;
      logic [CoordBits-1:0] win_x;
      logic [CoordBits-1:0] win_y;
      logic                 end_win;
      logic                 end_all;
   } pair_error_type;

endpackage

`default_nettype wire

// File: design/mssd_if.sv
`default_nettype none

// Request channel: one pixel pair per transfer
interface mssd_req_if
   import mssd_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [PixelBits-1:0] tgt_red;
   logic [PixelBits-1:0] tgt_green;
   logic [PixelBits-1:0] tgt_blue;
   logic                 tgt_hole;
   logic [PixelBits-1:0] cand_red;
   logic [PixelBits-1:0] cand_green;
   logic [PixelBits-1:0] cand_blue;
   logic                 cand_hole;
   logic [CoordBits-1:0] win_x;
   logic [CoordBits-1:0] win_y;
   logic                 last_in_window;
   logic                 last_window;

   modport source (
      output valid, tgt_red, tgt_green, tgt_blue, tgt_hole,
             cand_red, cand_green, cand_blue, cand_hole,
             win_x, win_y, last_in_window, last_window,
      input  ready
   );
   modport sink (
      input  valid, tgt_red, tgt_green, tgt_blue, tgt_hole,
             cand_red, cand_green, cand_blue, cand_hole,
             win_x, win_y, last_in_window, last_window,
      output ready
   );
endinterface

// Result channel: best window of one search
interface mssd_rsp_if
   import mssd_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CoordBits-1:0] best_x;
   logic [CoordBits-1:0] best_y;
   logic [ErrBits-1:0]   best_error;
   logic                 found;

   modport source (
      output valid, best_x, best_y, best_error, found,
      input  ready
   );
   modport sink (
      input  valid, best_x, best_y, best_error, found,
      output ready
   );
endinterface

`default_nettype wire

// File: design/mssd_sqdiff.sv
`default_nettype none

// Squared RGB difference of one pixel pair, registered
module mssd_sqdiff
   import mssd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic           pair_valid,
   input  wire pixel_pair_type pair,
   output logic                err_valid,
   output pair_error_type      err
);

   logic           valid_ff;
   pair_error_type err_ff;
   pair_error_type err_in;

   logic [PixelBits-1:0]   diff_r, diff_g, diff_b;
   logic [2*PixelBits-1:0] sq_r, sq_g, sq_b;
   logic [IncBits-1:0]     sum_sq;

   // absolute differences, then three independent squares
   always_comb begin
      diff_r = (pair.tgt_red   >= pair.cand_red)   ? pair.tgt_red   - pair.cand_red
                                                   : pair.cand_red  - pair.tgt_red;
      diff_g = (pair.tgt_green >= pair.cand_green) ? pair.tgt_green - pair.cand_green
                                                   : pair.cand_green - pair.tgt_green;
      diff_b = (pair.tgt_blue  >= pair.cand_blue)  ? pair.tgt_blue  - pair.cand_blue
                                                   : pair.cand_blue - pair.tgt_blue;
      sq_r   = diff_r * diff_r;
      sq_g   = diff_g * diff_g;
      sq_b   = diff_b * diff_b;
      sum_sq = IncBits'(sq_r) + IncBits'(sq_g) + IncBits'(sq_b);
   end

   // target holes contribute nothing; last_window also closes the window
   always_comb begin
      err_in.err_inc   = pair.tgt_hole ? '0 : sum_sq;
      err_in.cand_hole = pair.cand_hole;
      err_in.win_x     = pair.win_x;
      err_in.win_y     = pair.win_y;
      err_in.end_win   = pair.last_in_window | pair.last_window;
      err_in.end_all   = pair.last_window;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= pair_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err_ff <= err_in;
      end
   end

   assign err_valid = valid_ff;
   assign err       = err_ff;

endmodule

`default_nettype wire

// File: design/masked_ssd_patch_match_core.sv
`default_nettype none

// Masked SSD block matcher. Each request carries one target/candidate pixel
// pair; the core sums squared RGB differences over non-hole target pixels per
// window, drops windows holding any candidate hole, and keeps the first window
// with the strictly smallest error (sums saturate at 2^26-1). A request with
// last_window set closes the search and yields one response with the best
// position, its error and a found flag, after which the search state clears.
// Throughput is one request per clock unless the pipeline holds; a request
// passes an input register, the squared-difference register and the
// accumulate/compare stage into the response register. The whole pipeline
// holds only while a finished response waits in the output register, the
// receiver is not ready, and another search end reaches the accumulate stage.
module masked_ssd_patch_match_core
   import mssd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mssd_req_if.sink  req_chan,
   mssd_rsp_if.source rsp_chan
);

   logic           advance;
   logic           in_valid_ff;
   pixel_pair_type in_pair_ff;
   pixel_pair_type in_pair_in;
   logic           err_valid;
   pair_error_type err;

   // search state
   logic [ErrBits-1:0]   run_err_ff, run_err_in;
   logic                 rejected_ff, rejected_in;
   logic [ErrBits-1:0]   best_err_ff, best_err_in;
   logic [CoordBits-1:0] best_x_ff, best_x_in;
   logic [CoordBits-1:0] best_y_ff, best_y_in;
   logic                 found_ff, found_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CoordBits-1:0] rsp_x_ff, rsp_y_ff;
   logic [ErrBits-1:0]   rsp_err_ff;
   logic                 rsp_found_ff;

   logic [ErrBits:0]     acc_sum;
   logic [ErrBits-1:0]   acc_sat;
   logic                 win_rej;
   logic                 take;
   logic                 emit;

   // pipeline moves unless a search end meets a full output register not being read
   assign advance = !(err_valid && err.end_all && rsp_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = advance;

   always_comb begin
      in_pair_in.tgt_red        = req_chan.tgt_red;
      in_pair_in.tgt_green      = req_chan.tgt_green;
      in_pair_in.tgt_blue       = req_chan.tgt_blue;
      in_pair_in.tgt_hole       = req_chan.tgt_hole;
      in_pair_in.cand_red       = req_chan.cand_red;
      in_pair_in.cand_green     = req_chan.cand_green;
      in_pair_in.cand_blue      = req_chan.cand_blue;
      in_pair_in.cand_hole      = req_chan.cand_hole;
      in_pair_in.win_x          = req_chan.win_x;
      in_pair_in.win_y          = req_chan.win_y;
      in_pair_in.last_in_window = req_chan.last_in_window;
      in_pair_in.last_window    = req_chan.last_window;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_pair_ff <= in_pair_in;
      end
   end

   mssd_sqdiff u_sqdiff (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pair_valid (in_valid_ff),
      .pair       (in_pair_ff),
      .err_valid  (err_valid),
      .err        (err)
   );

   // accumulate, score the window at its end, emit at the search end
   always_comb begin
      acc_sum = {1'b0, run_err_ff} + (ErrBits + 1)'(err.err_inc);
      acc_sat = acc_sum[ErrBits] ? ErrAllOnes : acc_sum[ErrBits-1:0];
      win_rej = rejected_ff | err.cand_hole;
      take    = err.end_win && !win_rej && (!found_ff || acc_sat < best_err_ff);
      emit    = err_valid && advance && err.end_all;

      run_err_in  = run_err_ff;
      rejected_in = rejected_ff;
      best_err_in = best_err_ff;
      best_x_in   = best_x_ff;
      best_y_in   = best_y_ff;
      found_in    = found_ff;

      if (err_valid && advance) begin
         if (take) begin
            best_err_in = acc_sat;
            best_x_in   = err.win_x;
            best_y_in   = err.win_y;
            found_in    = 1'b1;
         end
         if (err.end_win) begin
            run_err_in  = '0;
            rejected_in = 1'b0;
         end else begin
            run_err_in  = acc_sat;
            rejected_in = win_rej;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || emit) begin
         run_err_ff  <= '0;
         rejected_ff <= 1'b0;
         best_err_ff <= ErrAllOnes;
         best_x_ff   <= '0;
         best_y_ff   <= '0;
         found_ff    <= 1'b0;
      end else begin
         run_err_ff  <= run_err_in;
         rejected_ff <= rejected_in;
         best_err_ff <= best_err_in;
         best_x_ff   <= best_x_in;
         best_y_ff   <= best_y_in;
         found_ff    <= found_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff     <= best_x_in;
         rsp_y_ff     <= best_y_in;
         rsp_err_ff   <= best_err_in;
         rsp_found_ff <= found_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.best_x     = rsp_x_ff;
   assign rsp_chan.best_y     = rsp_y_ff;
   assign rsp_chan.best_error = rsp_err_ff;
   assign rsp_chan.found      = rsp_found_ff;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
module tb_top;
   import mssd_pkg::*;

   localparam int ClockPeriod   = 20;
   localparam int ResetCycles   = 5;
   localparam int IdleLimit     = 3000;
   localparam int HoldOffCycles = 300;
   localparam int DrainCycles   = 12;
   localparam int RandomPairs   = 1150;
   // 345 pixels at full swing push a window past 2^26-1, 344 do not
   localparam int SatPixels     = 345;
   localparam int CoordMax      = (1 << CoordBits) - 1;

   typedef struct packed {
      logic [CoordBits-1:0] best_x;
      logic [CoordBits-1:0] best_y;
      logic [ErrBits-1:0]   best_error;
      logic                 found;
   } search_result_type;

   typedef enum {StallNone, StallRandom, StallPeriodic, StallSparse} stall_mode_type;

   logic clock;
   logic reset;

   mssd_req_if req_if ();
   mssd_rsp_if rsp_if ();

   masked_ssd_patch_match_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Search state mirrored by the matcher model
   logic [ErrBits-1:0]   window_err;
   logic                 window_dropped;
   logic [ErrBits-1:0]   best_err;
   logic [CoordBits-1:0] best_col;
   logic [CoordBits-1:0] best_row;
   logic                 best_valid;

   search_result_type search_results_q[$];

   int  pairs_sent     = 0;
   int  burst_left     = 0;
   int  mismatch_count = 0;
   int  results_seen   = 0;
   int  found_seen     = 0;
   int  saturated_seen = 0;
   int  idle_cycles    = 0;
   bit  hold_off_req   = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   function automatic int unsigned sq_diff(input logic [PixelBits-1:0] a,
                                           input logic [PixelBits-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   task automatic clear_search();
      window_err     = '0;
      window_dropped = 1'b0;
      best_err       = ErrAllOnes;
      best_col       = '0;
      best_row       = '0;
      best_valid     = 1'b0;
   endtask

   // Fold one accepted pixel pair into the search; queue a result on search end
   task automatic match_pair(input pixel_pair_type p);
      int unsigned total;
      search_result_type r;
      if (p.cand_hole) window_dropped = 1'b1;
      if (!p.tgt_hole) begin
         total = window_err + sq_diff(p.tgt_red, p.cand_red)
               + sq_diff(p.tgt_green, p.cand_green) + sq_diff(p.tgt_blue, p.cand_blue);
         window_err = (total > ErrAllOnes) ? ErrAllOnes : ErrBits'(total);
      end
      if (p.last_in_window || p.last_window) begin
         if (!window_dropped && (!best_valid || window_err < best_err)) begin
            best_err   = window_err;
            best_col   = p.win_x;
            best_row   = p.win_y;
            best_valid = 1'b1;
         end
         window_err     = '0;
         window_dropped = 1'b0;
      end
      if (p.last_window) begin
         r.best_x     = best_col;
         r.best_y     = best_row;
         r.best_error = best_err;
         r.found      = best_valid;
         search_results_q.push_back(r);
         clear_search();
      end
   endtask

   task automatic drive_pair(input logic valid, input pixel_pair_type p);
      req_if.valid          <= valid;
      req_if.tgt_red        <= p.tgt_red;
      req_if.tgt_green      <= p.tgt_green;
      req_if.tgt_blue       <= p.tgt_blue;
      req_if.tgt_hole       <= p.tgt_hole;
      req_if.cand_red       <= p.cand_red;
      req_if.cand_green     <= p.cand_green;
      req_if.cand_blue      <= p.cand_blue;
      req_if.cand_hole      <= p.cand_hole;
      req_if.win_x          <= p.win_x;
      req_if.win_y          <= p.win_y;
      req_if.last_in_window <= p.last_in_window;
      req_if.last_window    <= p.last_window;
   endtask

   // Offer one request; bursts of random length separated by random gaps
   task automatic send_pair(input pixel_pair_type p);
      int gap;
      gap = 0;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      drive_pair(1'b1, p);
      do @(posedge clock); while (!req_if.ready);
      pairs_sent++;
      match_pair(p);
   endtask

   function automatic pixel_pair_type mk_pair(
      input logic [PixelBits-1:0] tr, input logic [PixelBits-1:0] tg,
      input logic [PixelBits-1:0] tb, input logic th,
      input logic [PixelBits-1:0] cr, input logic [PixelBits-1:0] cg,
      input logic [PixelBits-1:0] cb, input logic ch,
      input logic [CoordBits-1:0] x, input logic [CoordBits-1:0] y,
      input logic liw, input logic lw);
      pixel_pair_type p;
      p.tgt_red        = tr;
      p.tgt_green      = tg;
      p.tgt_blue       = tb;
      p.tgt_hole       = th;
      p.cand_red       = cr;
      p.cand_green     = cg;
      p.cand_blue      = cb;
      p.cand_hole      = ch;
      p.win_x          = x;
      p.win_y          = y;
      p.last_in_window = liw;
      p.last_window    = lw;
      return p;
   endfunction

   // Fully random pair, no end marks
   function automatic pixel_pair_type rand_pair();
      return mk_pair($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 1),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 1),
                     $urandom_range(0, CoordMax), $urandom_range(0, CoordMax), 1'b0, 1'b0);
   endfunction

   // One well-formed search of n_win windows with random content
   task automatic send_search(input int n_win, input int max_len, input int tgt_hole_pct,
                              input int cand_hole_pct, input int close_pct,
                              input bit skip_end_mark);
      pixel_pair_type       p;
      int                   len;
      int                   hole_at;
      bit                   has_hole;
      bit                   close_vals;
      bit                   is_last_win;
      logic [CoordBits-1:0] col;
      logic [CoordBits-1:0] row;
      for (int w = 0; w < n_win; w++) begin
         len         = $urandom_range(1, max_len);
         col         = $urandom_range(0, CoordMax);
         row         = $urandom_range(0, CoordMax);
         has_hole    = $urandom_range(0, 99) < cand_hole_pct;
         hole_at     = $urandom_range(0, len - 1);
         close_vals  = $urandom_range(0, 99) < close_pct;
         is_last_win = (w == n_win - 1);
         for (int i = 0; i < len; i++) begin
            p = rand_pair();
            // near-equal pixels give small errors and frequent ties
            if (close_vals) begin
               p.cand_red   = p.tgt_red ^ PixelBits'($urandom_range(0, 1));
               p.cand_green = p.tgt_green ^ PixelBits'($urandom_range(0, 1));
               p.cand_blue  = p.tgt_blue ^ PixelBits'($urandom_range(0, 1));
            end
            p.tgt_hole       = $urandom_range(0, 99) < tgt_hole_pct;
            p.cand_hole      = has_hole && (i == hole_at || $urandom_range(0, 9) == 0);
            p.last_in_window = (i == len - 1) && !(is_last_win && skip_end_mark);
            p.last_window    = is_last_win && (i == len - 1);
            // only the final pixel's position counts; earlier ones often differ
            if (i == len - 1 || $urandom_range(0, 2) != 0) begin
               p.win_x = col;
               p.win_y = row;
            end
            send_pair(p);
         end
      end
   endtask

   // Unstructured requests: stray end marks, windows that never close
   task automatic send_noise(input int count);
      pixel_pair_type p;
      for (int i = 0; i < count; i++) begin
         p = rand_pair();
         p.last_in_window = ($urandom_range(0, 3) == 0);
         p.last_window    = ($urandom_range(0, 15) == 0);
         send_pair(p);
      end
   endtask

   task automatic test_single_pixel_searches();
      // exact match, then full swing in both directions at the corner positions
      send_pair(mk_pair(10, 20, 30, 0, 10, 20, 30, 0, 0, 0, 1, 1));
      send_pair(mk_pair(255, 255, 255, 0, 0, 0, 0, 0, CoordMax, CoordMax, 1, 1));
      send_pair(mk_pair(0, 0, 0, 0, 255, 255, 255, 0, CoordMax, 0, 1, 1));
   endtask

   task automatic test_best_window_choice();
      send_pair(mk_pair(0, 0, 0, 0, 255, 255, 255, 0, 1, 2, 1, 0));
      // error 2; position of the final pixel is the one kept
      send_pair(mk_pair(5, 5, 5, 0, 4, 5, 5, 0, 7, 7, 0, 0));
      send_pair(mk_pair(5, 5, 5, 0, 5, 5, 6, 0, 100, 200, 1, 0));
      // equal error does not replace the earlier window
      send_pair(mk_pair(9, 9, 9, 0, 10, 10, 9, 0, 300, 400, 1, 0));
      send_pair(mk_pair(0, 0, 0, 0, 3, 0, 0, 0, 500, 600, 1, 1));
   endtask

   task automatic test_hole_handling();
      // target hole adds nothing
      send_pair(mk_pair(255, 0, 255, 1, 0, 255, 0, 0, 11, 22, 0, 0));
      send_pair(mk_pair(40, 50, 60, 0, 40, 50, 60, 0, 33, 44, 1, 1));
      // candidate hole rejects even when the target pixel is a hole too
      send_pair(mk_pair(1, 2, 3, 1, 4, 5, 6, 1, 55, 66, 1, 1));
      // rejected window with zero error loses to a clean worse one
      send_pair(mk_pair(7, 7, 7, 0, 7, 7, 7, 1, 70, 80, 1, 0));
      send_pair(mk_pair(0, 0, 0, 0, 1, 1, 1, 0, 90, 91, 1, 1));
      send_pair(mk_pair(255, 255, 255, 1, 0, 0, 0, 0, 12, 13, 1, 1));
   endtask

   task automatic test_end_marks();
      // search end without window end still scores the open window
      send_pair(mk_pair(10, 0, 0, 0, 0, 0, 0, 0, 5, 6, 1, 0));
      send_pair(mk_pair(0, 0, 0, 0, 0, 0, 2, 0, 8, 9, 0, 1));
      send_pair(mk_pair(3, 0, 0, 0, 0, 0, 0, 0, 2, 3, 0, 1));
      send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 1, 4, 4, 0, 1));
   endtask

   task automatic test_error_saturation();
      logic [PixelBits-1:0] t_val;
      logic [PixelBits-1:0] c_val;
      logic [CoordBits-1:0] x;
      // first kept window is taken even when saturated; an equal second one is not
      for (int w = 0; w < 2; w++) begin
         t_val = (w == 0) ? 8'd255 : 8'd0;
         c_val = ~t_val;
         x     = (w == 0) ? 12'd17 : 12'd4095;
         for (int i = 0; i < SatPixels; i++)
            send_pair(mk_pair(t_val, t_val, t_val, 0, c_val, c_val, c_val, 0, x, x,
                              i == SatPixels - 1, w == 1 && i == SatPixels - 1));
      end
   endtask

   task automatic test_backpressure();
      pixel_pair_type p;
      // receiver stops for a long stretch while one-pixel searches keep coming
      hold_off_req = 1'b1;
      for (int i = 0; i < 60; i++) begin
         p = rand_pair();
         p.last_in_window = 1'b1;
         p.last_window    = 1'b1;
         send_pair(p);
      end
   endtask

   task automatic test_random_searches();
      int stop_at;
      int pick;
      stop_at = pairs_sent + RandomPairs;
      while (pairs_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            send_search($urandom_range(1, 6), 9, 20, 30, 30, $urandom_range(0, 4) == 0);
         else if (pick < 78)
            send_search($urandom_range(1, 4), 9, $urandom_range(0, 100), 90, 20,
                        $urandom_range(0, 1));
         else if (pick < 88)
            send_noise($urandom_range(1, 20));
         else if (pick < 97)
            send_search($urandom_range(2, 8), 4, 10, 10, 100, 1'b0);
         else
            send_search($urandom_range(1, 2), 225, 10, 20, 0, 1'b0);
      end
   endtask

   // Receiver: randomly chosen stall patterns that change at random, plus one long hold-off
   initial begin
      stall_mode_type mode;
      int             mode_left;
      rsp_if.ready = 1'b0;
      mode         = StallNone;
      mode_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         if (mode_left <= 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         case (mode)
            StallNone:     rsp_if.ready <= 1'b1;
            StallRandom:   rsp_if.ready <= $urandom_range(0, 1);
            StallPeriodic: rsp_if.ready <= (mode_left % 4 == 0);
            default:       rsp_if.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Result check against the oldest queued search result
   always @(posedge clock) begin
      search_result_type exp_r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (search_results_q.size() == 0) begin
            $error("unexpected result: best_x %0d best_y %0d best_error %0d found %0b",
                   rsp_if.best_x, rsp_if.best_y, rsp_if.best_error, rsp_if.found);
            mismatch_count++;
         end else begin
            exp_r = search_results_q.pop_front();
            results_seen++;
            if (exp_r.found) found_seen++;
            if (exp_r.found && exp_r.best_error == ErrAllOnes) saturated_seen++;
            if (rsp_if.best_x !== exp_r.best_x) begin
               $error("best_x: expected %0d, got %0d", exp_r.best_x, rsp_if.best_x);
               mismatch_count++;
            end
            if (rsp_if.best_y !== exp_r.best_y) begin
               $error("best_y: expected %0d, got %0d", exp_r.best_y, rsp_if.best_y);
               mismatch_count++;
            end
            if (rsp_if.best_error !== exp_r.best_error) begin
               $error("best_error: expected %0d, got %0d", exp_r.best_error,
                      rsp_if.best_error);
               mismatch_count++;
            end
            if (rsp_if.found !== exp_r.found) begin
               $error("found: expected %0b, got %0b", exp_r.found, rsp_if.found);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Test sequence
   initial begin
      reset = 1'b1;
      drive_pair(1'b0, '0);
      clear_search();
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_pixel_searches();
      test_best_window_choice();
      test_hole_handling();
      test_end_marks();
      test_error_saturation();
      test_backpressure();
      test_random_searches();

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (search_results_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d pixel pairs; checked %0d search results", pairs_sent, results_seen);
      $display("Results with a match: %0d (saturated: %0d), without a match: %0d",
               found_seen, saturated_seen, results_seen - found_seen);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
